// ----- rtl/pmp_rc_pkg.sv -----
package pmp_rc_pkg;

    // Region permission flags as held in each table entry.
    typedef struct packed {
        logic lock;
        logic exec;
        logic write;
        logic read;
        logic valid;
    } t_region_flags;

    // What one lane found for the item it checked.
    typedef struct packed {
        logic fetch_hit;
        logic data_hit;
        logic read;
        logic write;
        logic exec;
    } t_lane_hit;

    // Width of the func selector in tuser and of the region index field.
    localparam int unsigned FUNC_BITS  = 1;
    localparam int unsigned INDEX_BITS = 4;
    localparam int unsigned FLAG_BITS  = 5;

    // func codes
    localparam logic [FUNC_BITS-1:0] FUNC_CHECK = 1'b0;
    localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 1'b1;

    // Result tdata: read, write, exec from bit 0 up, padded to a byte.
    localparam int unsigned RESULT_BITS = 3;
    localparam int unsigned M_TDATA_BITS = 8;

endpackage

// ----- rtl/pmp_rc_lane.sv -----
module pmp_rc_lane
    import pmp_rc_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,        // item accepted this cycle
    input  logic                 i_wr_en,       // replace this lane's entry
    input  logic                 i_check_enable,
    input  logic [ADDR_BITS-1:0] i_fetch_address,
    input  logic [ADDR_BITS-1:0] i_data_address,
    input  logic [ADDR_BITS-1:0] i_new_start,
    input  logic [ADDR_BITS-1:0] i_new_end,
    input  t_region_flags        i_new_flags,
    output t_lane_hit            o_hit
);

    logic [ADDR_BITS-1:0] r_start;
    logic [ADDR_BITS-1:0] r_end;
    t_region_flags        r_flags;
    t_lane_hit            r_hit;
    t_lane_hit            n_hit;
    logic                 w_active;

    // Region counts only if valid and either checking is on or it is locked.
    assign w_active = r_flags.valid && (i_check_enable || r_flags.lock);

    always_comb begin
        n_hit.fetch_hit = w_active && (i_fetch_address >= r_start)
                          && (i_fetch_address <= r_end);
        n_hit.data_hit  = w_active && (i_data_address >= r_start)
                          && (i_data_address <= r_end);
        n_hit.read      = r_flags.read;
        n_hit.write     = r_flags.write;
        n_hit.exec      = r_flags.exec;
    end

    // Compare uses the entry before this edge; the write lands after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_flags <= '0;
        end else if (i_wr_en) begin
            r_start <= i_new_flags.valid ? i_new_start : '0;
            r_end   <= i_new_flags.valid ? i_new_end : '0;
            r_flags <= i_new_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

// ----- rtl/pmp_rc_merge.sv -----
module pmp_rc_merge
    import pmp_rc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic                    i_check_enable,
    input  t_lane_hit [ENTRIES-1:0] i_hits,
    output logic [RESULT_BITS-1:0]  o_result   // read, write, exec from bit 0
);

    logic                   w_read;
    logic                   w_write;
    logic                   w_exec;
    logic [RESULT_BITS-1:0] r_result;

    // Lowest-numbered hit wins: walk down so lower lanes overwrite.
    always_comb begin
        w_read  = !i_check_enable;
        w_write = !i_check_enable;
        w_exec  = !i_check_enable;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (i_hits[i].fetch_hit) begin
                w_exec = i_hits[i].exec;
            end
            if (i_hits[i].data_hit) begin
                w_read  = i_hits[i].read;
                w_write = i_hits[i].write;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= {w_exec, w_write, w_read};
        end
    end

    assign o_result = r_result;

endmodule

// ----- rtl/pmp_region_checker_top.sv -----
// PMP region checker: one lane per table entry compares both addresses,
// a priority merge picks the lowest-numbered matching region.
// Each item passes the lane hit registers, then the merged result register, to the master side.
// Throughput: one item per cycle while the master side accepts; lanes compare in parallel, merge is registered.
// A region write in an item takes effect for the next item.
// Reset (i_rst_n low, synchronous) clears the whole table and both stages.
module pmp_region_checker_top
    import pmp_rc_pkg::*;
#(
    parameter int unsigned ENTRIES   = 16,
    parameter int unsigned ADDR_BITS = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Slave side.
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata from bit 0: check_enable, fetch_address, data_address,
    // region_index, new_start, new_end, new_valid, new_lock, new_read,
    // new_write, new_exec, zero pad
    input  logic [((4*ADDR_BITS+INDEX_BITS+FLAG_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: func
    input  logic [FUNC_BITS-1:0] i_s_axis_tuser,
    // Master side.
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // tdata from bit 0: allow_read, allow_write, allow_exec, zero pad
    output logic [M_TDATA_BITS-1:0] o_m_axis_tdata
);

    // Field offsets in the slave tdata.
    localparam int unsigned OFS_EN    = 0;
    localparam int unsigned OFS_FETCH = OFS_EN + 1;
    localparam int unsigned OFS_DATA  = OFS_FETCH + ADDR_BITS;
    localparam int unsigned OFS_INDEX = OFS_DATA + ADDR_BITS;
    localparam int unsigned OFS_START = OFS_INDEX + INDEX_BITS;
    localparam int unsigned OFS_END   = OFS_START + ADDR_BITS;
    localparam int unsigned OFS_VALID = OFS_END + ADDR_BITS;
    localparam int unsigned OFS_LOCK  = OFS_VALID + 1;
    localparam int unsigned OFS_READ  = OFS_LOCK + 1;
    localparam int unsigned OFS_WRITE = OFS_READ + 1;
    localparam int unsigned OFS_EXEC  = OFS_WRITE + 1;

    logic                  w_in_acc;
    logic                  w_s1_adv;
    logic                  w_is_write;
    logic                  w_check_enable;
    logic [ADDR_BITS-1:0]  w_fetch_address;
    logic [ADDR_BITS-1:0]  w_data_address;
    logic [INDEX_BITS-1:0] w_region_index;
    logic [ADDR_BITS-1:0]  w_new_start;
    logic [ADDR_BITS-1:0]  w_new_end;
    t_region_flags         w_new_flags;
    logic [ENTRIES-1:0]    w_wr_en;
    t_lane_hit [ENTRIES-1:0] w_hits;
    logic [RESULT_BITS-1:0]  w_result;

    logic r_s1_valid;
    logic r_s1_enable;
    logic r_out_valid;

    // Field unpack.
    assign w_check_enable  = i_s_axis_tdata[OFS_EN];
    assign w_fetch_address = i_s_axis_tdata[OFS_FETCH +: ADDR_BITS];
    assign w_data_address  = i_s_axis_tdata[OFS_DATA +: ADDR_BITS];
    assign w_region_index  = i_s_axis_tdata[OFS_INDEX +: INDEX_BITS];
    assign w_new_start     = i_s_axis_tdata[OFS_START +: ADDR_BITS];
    assign w_new_end       = i_s_axis_tdata[OFS_END +: ADDR_BITS];
    assign w_new_flags.valid = i_s_axis_tdata[OFS_VALID];
    assign w_new_flags.lock  = i_s_axis_tdata[OFS_LOCK];
    assign w_new_flags.read  = i_s_axis_tdata[OFS_READ];
    assign w_new_flags.write = i_s_axis_tdata[OFS_WRITE];
    assign w_new_flags.exec  = i_s_axis_tdata[OFS_EXEC];

    // Two-stage pipeline: lane hit regs, then merged result reg.
    // Each stage moves when the one after it is empty or draining.
    assign w_s1_adv        = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_write      = (i_s_axis_tuser == FUNC_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_enable <= w_check_enable;
        end
    end

    // One lane per entry; indexes at or past ENTRIES match no lane.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        assign w_wr_en[g] = w_in_acc && w_is_write && (32'(w_region_index) == g);

        pmp_rc_lane #(
            .ADDR_BITS(ADDR_BITS)
        ) u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_load         (w_in_acc),
            .i_wr_en        (w_wr_en[g]),
            .i_check_enable (w_check_enable),
            .i_fetch_address(w_fetch_address),
            .i_data_address (w_data_address),
            .i_new_start    (w_new_start),
            .i_new_end      (w_new_end),
            .i_new_flags    (w_new_flags),
            .o_hit          (w_hits[g])
        );
    end

    pmp_rc_merge #(
        .ENTRIES(ENTRIES)
    ) u_merge (
        .i_clk         (i_clk),
        .i_load        (w_s1_adv),
        .i_check_enable(r_s1_enable),
        .i_hits        (w_hits),
        .o_result      (w_result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_BITS-RESULT_BITS){1'b0}}, w_result};

    // An item held in stage 1 is never dropped while blocked.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_adv |=> r_s1_valid)
        else $error("stage 1 item lost while stalled");

    // An accepted item always occupies stage 1 next cycle.
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted item not held in stage 1");

    // A stage 1 advance always produces a result.
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("stage 1 advance produced no result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

endmodule

// ----- sim/pmp_region_checker_top_tb.sv -----
module pmp_region_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pmp_rc_pkg::*;

    localparam int unsigned ENTRIES   = 16;
    localparam int unsigned ADDR_BITS = 48;
    localparam int unsigned S_BITS    = ((4*ADDR_BITS+INDEX_BITS+FLAG_BITS+1+7)/8)*8;
    localparam int unsigned N_RANDOM  = 800;
    localparam int unsigned STALL_LIMIT = 5000;  // cycles with no transfer on either side
    localparam int unsigned HOLD_CYCLES = 300;   // long master-side hold-off
    localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

    typedef logic [ADDR_BITS-1:0] t_addr;

    // One check item; the region fields only matter for FUNC_WRITE.
    typedef struct {
        logic [FUNC_BITS-1:0]  func;
        logic                  enable;
        t_addr                 fetch;
        t_addr                 data;
        logic [INDEX_BITS-1:0] index;
        t_addr                 nstart;
        t_addr                 nend;
        t_region_flags         nflags;
    } t_pmp_item;

    // Result tdata layout, read in bit 0.
    typedef struct packed {
        logic exec;
        logic write;
        logic read;
    } t_perm;

    // Shadow of the region table plus the queue of permissions still owed.
    class perm_scoreboard;
        t_addr         region_lo [ENTRIES];
        t_addr         region_hi [ENTRIES];
        t_region_flags region_fl [ENTRIES];
        t_perm         expected_perms [$];
        int            errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                region_lo[i] = '0;
                region_hi[i] = '0;
                region_fl[i] = '0;
            end
            errors = 0;
        endfunction

        function bit region_hits(int i, t_addr a, logic en);
            return region_fl[i].valid && (en || region_fl[i].lock) &&
                   a >= region_lo[i] && a <= region_hi[i];
        endfunction

        // Lowest-numbered applicable region wins; no hit gives ~enable.
        function t_perm lookup_perms(logic en, t_addr fetch, t_addr data);
            t_perm p;
            bit    fetch_done;
            bit    data_done;
            p = {3{~en}};
            fetch_done = 0;
            data_done  = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!fetch_done && region_hits(i, fetch, en)) begin
                    p.exec = region_fl[i].exec;
                    fetch_done = 1;
                end
                if (!data_done && region_hits(i, data, en)) begin
                    p.read  = region_fl[i].read;
                    p.write = region_fl[i].write;
                    data_done = 1;
                end
            end
            return p;
        endfunction

        function void note_input(t_pmp_item it);
            expected_perms.push_back(lookup_perms(it.enable, it.fetch, it.data));
            // table update lands after the check
            if (it.func == FUNC_WRITE && it.index < ENTRIES) begin
                region_lo[it.index] = it.nflags.valid ? it.nstart : '0;
                region_hi[it.index] = it.nflags.valid ? it.nend : '0;
                region_fl[it.index] = it.nflags;
            end
        endfunction

        function void compare_bit(string field, logic want, logic got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %b actual %b", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] d);
            t_perm want;
            t_perm got;
            got = d[RESULT_BITS-1:0];
            if (expected_perms.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %b", $time, got);
                errors++;
                return;
            end
            want = expected_perms.pop_front();
            compare_bit("allow_read", want.read, got.read);
            compare_bit("allow_write", want.write, got.write);
            compare_bit("allow_exec", want.exec, got.exec);
        endfunction

        function int pending();
            return expected_perms.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_BITS-1:0]       s_tdata = '0;        // enable, fetch, data, index, start, end, flags
    logic [FUNC_BITS-1:0]    s_tuser = FUNC_CHECK; // func
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;            // read, write, exec, pad

    perm_scoreboard sb = new();

    int    items_sent = 0;
    int    results_seen = 0;
    t_addr window_base;
    t_addr bound_pool [$];  // recently written region bounds, for hits at the edges

    pmp_region_checker_top #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_region_flags mk_flags(logic v, logic l, logic r, logic w, logic x);
        t_region_flags f;
        f.valid = v;
        f.lock  = l;
        f.read  = r;
        f.write = w;
        f.exec  = x;
        return f;
    endfunction

    function automatic t_pmp_item mk_check(logic en, t_addr fetch, t_addr data);
        t_pmp_item it;
        it.func   = FUNC_CHECK;
        it.enable = en;
        it.fetch  = fetch;
        it.data   = data;
        it.index  = '0;
        it.nstart = '0;
        it.nend   = '0;
        it.nflags = '0;
        return it;
    endfunction

    function automatic t_pmp_item mk_write(logic en, t_addr fetch, t_addr data,
                                           int idx, t_addr lo, t_addr hi, t_region_flags f);
        t_pmp_item it;
        it = mk_check(en, fetch, data);
        it.func   = FUNC_WRITE;
        it.index  = INDEX_BITS'(idx);
        it.nstart = lo;
        it.nend   = hi;
        it.nflags = f;
        return it;
    endfunction

    function automatic t_addr rand_addr();
        return t_addr'({$urandom(), $urandom()});
    endfunction

    // Mostly addresses inside one small window so random regions actually hit;
    // the rest are full-range, extremes, or on or next to a written bound.
    function automatic t_addr pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return rand_addr();
        if (r < 20)
            return $urandom_range(0, 1) ? ADDR_MAX : '0;
        if (r < 45 && bound_pool.size() != 0)
            return bound_pool[$urandom_range(0, bound_pool.size()-1)] +
                   t_addr'($urandom_range(0, 2)) - t_addr'(1);
        return window_base + t_addr'($urandom_range(0, 4095));
    endfunction

    function automatic t_pmp_item random_item();
        t_pmp_item it;
        t_addr     lo;
        t_addr     hi;
        lo = pick_addr();
        hi = ($urandom_range(0, 99) < 70) ? lo + t_addr'($urandom_range(0, 1023)) : pick_addr();
        it = mk_write(1'($urandom_range(0, 1)), pick_addr(), pick_addr(),
                      $urandom_range(0, 15), lo, hi,
                      mk_flags($urandom_range(0, 99) < 85, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1))));
        if ($urandom_range(0, 99) < 70) begin
            it.func = FUNC_CHECK;
        end else begin
            bound_pool.push_back(lo);
            bound_pool.push_back(hi);
            while (bound_pool.size() > 16) void'(bound_pool.pop_front());
        end
        return it;
    endfunction

    // Offer one item and hold it until the slave side takes the transfer.
    task automatic send_item(t_pmp_item it);
        // random gaps, except for a stretch in the middle of the run
        if ((items_sent < 300 || items_sent >= 500) && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= S_BITS'({it.nflags.exec, it.nflags.write, it.nflags.read,
                             it.nflags.lock, it.nflags.valid, it.nend, it.nstart,
                             it.index, it.data, it.fetch, it.enable});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(it);
        items_sent++;
    endtask

    // Master side: check every transfer, stall now and then, and once hold
    // off long enough that the pipeline backs up into the slave side.
    initial begin
        bit held;
        held = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                results_seen++;
            end
            if (!held && results_seen == 150) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= (results_seen >= 400 && results_seen < 600) ||
                            $urandom_range(0, 99) >= 10;
            end
        end
    end

    // Watchdog: any transfer on either side resets the count.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_region_flags none;
        none = '0;
        window_base = rand_addr() & ~t_addr'(12'hFFF);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: everything falls through to ~enable
        send_item(mk_check(1'b1, '0, ADDR_MAX));
        send_item(mk_check(1'b0, ADDR_MAX, '0));
        // write read-only region 0; same item still sees the old table
        send_item(mk_write(1'b1, 48'h1000, 48'h1000, 0, 48'h1000, 48'h1FFF,
                           mk_flags(1, 0, 1, 0, 0)));
        // inclusive bounds and just outside them
        send_item(mk_check(1'b1, 48'h1000, 48'h1FFF));
        send_item(mk_check(1'b1, 48'h0FFF, 48'h2000));
        // unlocked region ignored with checking off
        send_item(mk_check(1'b0, 48'h1500, 48'h1500));
        // locked catch-all in the last entry
        send_item(mk_write(1'b0, '0, '0, 15, '0, ADDR_MAX, mk_flags(1, 1, 1, 1, 1)));
        send_item(mk_check(1'b0, '0, 48'h1500));
        send_item(mk_check(1'b1, ADDR_MAX, 48'h1500));
        // overlapping locked write/exec region: priority vs. lock
        send_item(mk_write(1'b1, 48'h1800, 48'h1800, 1, 48'h1800, 48'h2800,
                           mk_flags(1, 1, 0, 1, 1)));
        send_item(mk_check(1'b1, 48'h1800, 48'h1800));
        send_item(mk_check(1'b0, 48'h1800, 48'h1800));
        // start above end matches nothing
        send_item(mk_write(1'b1, '0, '0, 2, 48'h5000, 48'h4000, mk_flags(1, 1, 0, 0, 0)));
        send_item(mk_check(1'b1, 48'h4800, 48'h5000));
        // invalid write drops region 0, addresses stored as zero
        send_item(mk_write(1'b1, '0, '0, 0, 48'h1000, 48'h1FFF, mk_flags(0, 1, 1, 1, 1)));
        send_item(mk_check(1'b1, 48'h1500, 48'h1500));
        // single-address regions at both ends of the space
        send_item(mk_write(1'b1, '0, '0, 15, ADDR_MAX, ADDR_MAX, mk_flags(1, 1, 0, 0, 1)));
        send_item(mk_write(1'b0, '0, '0, 3, '0, '0, mk_flags(1, 1, 1, 1, 0)));
        send_item(mk_check(1'b0, ADDR_MAX, '0));
        send_item(mk_check(1'b1, ADDR_MAX - 1, 48'h1));
        send_item(mk_check(1'b1, '0, ADDR_MAX));
        // clear the table edges again
        send_item(mk_write(1'b1, '0, '0, 3, '0, '0, none));
        send_item(mk_write(1'b0, '0, '0, 15, ADDR_MAX, '0, none));

        for (int n = 0; n < N_RANDOM; n++)
            send_item(random_item());
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
